// File: rtl/core/hkm_pkg.sv
`timescale 1ns / 1ps

package hkm_pkg;

  localparam int KEY_W       = 8;
  localparam int MOD_W       = 3;
  localparam int IDX_W       = 4;
  localparam int HANDLE_W    = 8;
  localparam int TIMER_W     = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_REGS    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MOD_W-1:0] SHIFT_BIT = 3'b001;
  localparam logic [MOD_W-1:0] CTRL_BIT  = 3'b010;
  localparam logic [MOD_W-1:0] ALT_BIT   = 3'b100;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_WRITE   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_SHIFT    = 3'd0,
    CFG_RIGHT_SHIFT   = 3'd1,
    CFG_LEFT_CTRL     = 3'd2,
    CFG_RIGHT_CTRL    = 3'd3,
    CFG_LEFT_ALT      = 3'd4,
    CFG_RIGHT_ALT     = 3'd5,
    CFG_INSERT        = 3'd6,
    CFG_KEYPAD_INSERT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_PRESS = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } back_state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [KEY_W-1:0]    keycode;
    logic [IDX_W-1:0]    entry_index;
    logic [KEY_W-1:0]    entry_first_key;
    logic [KEY_W-1:0]    entry_second_key;
    logic [MOD_W-1:0]    entry_modifiers;
    logic [HANDLE_W-1:0] entry_handle;
    logic                entry_valid;
  } item_t;

  typedef struct packed {
    logic                activated;
    logic [HANDLE_W-1:0] fired_handle;
    logic                matched;
    logic                waiting_second;
    logic [MOD_W-1:0]    modifiers_now;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]    first_key;
    logic [KEY_W-1:0]    second_key;
    logic [MOD_W-1:0]    modifiers;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [MOD_W-1:0] mods;
    logic [IDX_W-1:0] e_index;
    entry_t           e_data;
    logic             e_valid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/core/two_key_hotkey_matcher.sv
// Each accepted item is written into the queue; the back end pops it when idle and
// registers its result and done. A key press may first check the awaited slot, then scan.
// While a press scans the table through the single read port, one slot per cycle, later
// items wait in a two-item queue, which absorbs bursts; busy shows the queue is full.
// Reset (rst, synchronous) clears the code registers, modifiers, queue, the wait and every table slot's valid bit.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps

module two_key_hotkey_matcher
  import hkm_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int WAIT_TICKS  = 500
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 start,
  input  item_t                item,
  output logic                 busy,
  output logic                 done,
  output result_t              result
);

  logic          push;
  logic          pop;
  cmd_t          cmd_in;
  cmd_t          cmd_head;
  queue_status_t status;

  hkm_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .start    (start),
    .item     (item),
    .status   (status),
    .push     (push),
    .cmd      (cmd_in),
    .busy     (busy)
  );

  hkm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_head),
    .status(status)
  );

  hkm_back #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .WAIT_TICKS (WAIT_TICKS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .head  (cmd_head),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

// File: rtl/core/hkm_queue.sv
`timescale 1ns / 1ps

module hkm_queue
  import hkm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          din,
  input  logic          pop,
  output cmd_t          dout,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign dout         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/hkm_front.sv
`timescale 1ns / 1ps

module hkm_front
  import hkm_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 start,
  input  item_t                item,
  input  queue_status_t        status,
  output logic                 push,
  output cmd_t                 cmd,
  output logic                 busy
);

  logic [KEY_W-1:0] cfg_regs [CFG_REGS];
  logic [MOD_W-1:0] mask;
  logic [MOD_W-1:0] mask_next;
  logic [MOD_W-1:0] mod_bit;

  assign busy = status.full;
  assign push = start && !status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    if (item.keycode == cfg_regs[CFG_LEFT_SHIFT] || item.keycode == cfg_regs[CFG_RIGHT_SHIFT]) begin
      mod_bit = SHIFT_BIT;
    end else if (item.keycode == cfg_regs[CFG_LEFT_CTRL] ||
                 item.keycode == cfg_regs[CFG_RIGHT_CTRL]) begin
      mod_bit = CTRL_BIT;
    end else if (item.keycode == cfg_regs[CFG_LEFT_ALT] ||
                 item.keycode == cfg_regs[CFG_RIGHT_ALT]) begin
      mod_bit = ALT_BIT;
    end else begin
      mod_bit = '0;
    end
  end

  always_comb begin
    mask_next = mask;
    cmd.kind  = CMD_NOP;
    cmd.key   = (item.keycode == cfg_regs[CFG_KEYPAD_INSERT]) ? cfg_regs[CFG_INSERT]
                                                               : item.keycode;
    unique case (item.opcode)
      OP_PRESS: begin
        if (mod_bit != '0) begin
          mask_next = mask | mod_bit;
        end else begin
          cmd.kind = CMD_PRESS;
        end
      end
      OP_RELEASE: begin
        mask_next = mask & ~mod_bit;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
      end
      OP_WRITE: begin
        if (int'(item.entry_index) < TABLE_SLOTS) begin
          cmd.kind = CMD_WRITE;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
    cmd.mods              = mask_next;
    cmd.e_index           = item.entry_index;
    cmd.e_valid           = item.entry_valid;
    cmd.e_data.first_key  = item.entry_valid ? item.entry_first_key : '0;
    cmd.e_data.second_key = item.entry_valid ? item.entry_second_key : '0;
    cmd.e_data.modifiers  = item.entry_valid ? item.entry_modifiers : '0;
    cmd.e_data.handle     = item.entry_valid ? item.entry_handle : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (push) begin
      mask <= mask_next;
    end
  end

endmodule

// File: rtl/core/hkm_back.sv
`timescale 1ns / 1ps

module hkm_back
  import hkm_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int WAIT_TICKS  = 500
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t status,
  input  cmd_t          head,
  output logic          pop,
  output logic          done,
  output result_t       result
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  entry_t              mem [TABLE_SLOTS];
  entry_t              rd_entry;
  logic [SLOT_W-1:0]   rd_addr;
  logic [SLOT_W-1:0]   wr_addr;
  logic                wr_en;
  logic [TABLE_SLOTS-1:0] vld;

  back_state_t         state;
  cmd_t                cur;
  logic [SLOT_W-1:0]   scan_idx;
  logic                pending;
  logic [SLOT_W-1:0]   pending_slot;
  logic [TIMER_W-1:0]  timer;

  logic                tick_keep;
  logic                write_cancel;
  logic                check_hit;
  logic                scan_hit;

  assign pop     = (state == S_IDLE) && !status.empty;
  assign wr_en   = pop && (head.kind == CMD_WRITE);
  assign wr_addr = SLOT_W'(head.e_index);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = pending ? pending_slot : '0;
      S_CHECK: rd_addr = '0;
      S_SCAN:  rd_addr = (scan_idx == LAST_SLOT) ? '0 : scan_idx + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head.e_data;
    end
    rd_entry <= mem[rd_addr];
  end

  assign tick_keep    = pending && (timer > TIMER_W'(1));
  assign write_cancel = pending && (pending_slot == wr_addr);
  assign check_hit    = (rd_entry.second_key == cur.key) && (rd_entry.modifiers == cur.mods);
  assign scan_hit     = vld[scan_idx] && (rd_entry.first_key == cur.key) &&
                        (rd_entry.modifiers == cur.mods);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pending      <= 1'b0;
      pending_slot <= '0;
      timer        <= '0;
      vld          <= '0;
      scan_idx     <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!status.empty) begin
            cur                  <= head;
            result.activated     <= 1'b0;
            result.fired_handle  <= '0;
            result.matched       <= 1'b0;
            result.modifiers_now <= head.mods;
            unique case (head.kind)
              CMD_NOP: begin
                result.waiting_second <= pending;
                done                  <= 1'b1;
              end
              CMD_TICK: begin
                pending               <= tick_keep;
                timer                 <= tick_keep ? timer - 1'b1 : '0;
                result.waiting_second <= tick_keep;
                done                  <= 1'b1;
              end
              CMD_WRITE: begin
                vld[wr_addr] <= head.e_valid;
                if (write_cancel) begin
                  pending <= 1'b0;
                  timer   <= '0;
                end
                result.waiting_second <= pending && !write_cancel;
                done                  <= 1'b1;
              end
              CMD_PRESS: begin
                scan_idx <= '0;
                state    <= pending ? S_CHECK : S_SCAN;
              end
              default: begin
                result.waiting_second <= pending;
                done                  <= 1'b1;
              end
            endcase
          end
        end
        S_CHECK: begin
          pending <= 1'b0;
          timer   <= '0;
          if (check_hit) begin
            result.activated      <= 1'b1;
            result.fired_handle   <= rd_entry.handle;
            result.matched        <= 1'b1;
            result.waiting_second <= 1'b0;
            done                  <= 1'b1;
            state                 <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            result.matched <= 1'b1;
            if (rd_entry.second_key == '0) begin
              result.activated      <= 1'b1;
              result.fired_handle   <= rd_entry.handle;
              result.waiting_second <= pending;
            end else begin
              pending               <= 1'b1;
              pending_slot          <= scan_idx;
              timer                 <= TIMER_W'(WAIT_TICKS);
              result.waiting_second <= 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (scan_idx == LAST_SLOT) begin
            result.waiting_second <= pending;
            done                  <= 1'b1;
            state                 <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/hkm_checker.sv
`timescale 1ns / 1ps

module hkm_checker
  import hkm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    done,
  input result_t result
);

  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe straight after reset");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.activated |-> result.fired_handle == '0)
    else $error("handle reported without activation");

  a_fire_is_match: assert property (@(posedge clk) disable iff (rst)
    done && result.activated |-> result.matched)
    else $error("activation without a match");

  a_arm_waits: assert property (@(posedge clk) disable iff (rst)
    done && result.matched && !result.activated |-> result.waiting_second)
    else $error("first part matched but no second key awaited");

endmodule

bind two_key_hotkey_matcher hkm_checker u_hkm_checker (
  .clk   (clk),
  .rst   (rst),
  .done  (done),
  .result(result)
);

// File: sim/tb_two_key_hotkey_matcher.sv
`timescale 1ns / 1ps

module tb_two_key_hotkey_matcher;
  import hkm_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int WAIT_TICKS  = 500;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = TABLE_SLOTS + 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;
  logic                 start = 1'b0;
  item_t                item = '0;
  logic                 busy;
  logic                 done;
  result_t              result;

  two_key_hotkey_matcher #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .WAIT_TICKS (WAIT_TICKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  // matcher state as predicted
  logic [KEY_W-1:0]       key_cfg [CFG_REGS];
  logic [MOD_W-1:0]       held_mods;
  logic                   awaiting;
  logic [IDX_W-1:0]       await_slot;
  logic [TIMER_W-1:0]     ticks_left;
  entry_t                 hotkeys [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] hotkey_on;

  // table and modifiers as the stimulus will have left them
  entry_t                 gen_tab [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] gen_on;
  logic [MOD_W-1:0]       gen_mods;

  item_t   key_events [$];
  result_t predicted_results [$];

  int gen_count = 0;
  int accepted = 0;
  int checked = 0;
  int fired = 0;
  int armed = 0;
  int errors = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic logic [MOD_W-1:0] mod_of(logic [KEY_W-1:0] k);
    if (k == key_cfg[CFG_LEFT_SHIFT] || k == key_cfg[CFG_RIGHT_SHIFT]) return SHIFT_BIT;
    if (k == key_cfg[CFG_LEFT_CTRL] || k == key_cfg[CFG_RIGHT_CTRL]) return CTRL_BIT;
    if (k == key_cfg[CFG_LEFT_ALT] || k == key_cfg[CFG_RIGHT_ALT]) return ALT_BIT;
    return '0;
  endfunction

  function automatic entry_t entry_of(item_t it);
    entry_t e;
    e = '0;
    if (it.entry_valid) begin
      e.first_key  = it.entry_first_key;
      e.second_key = it.entry_second_key;
      e.modifiers  = it.entry_modifiers;
      e.handle     = it.entry_handle;
    end
    return e;
  endfunction

  function automatic result_t hotkey_step(item_t it);
    result_t          r;
    logic [MOD_W-1:0] bit_m;
    logic [KEY_W-1:0] key;
    logic             hit;
    int               i;
    r = '0;
    key = it.keycode;
    bit_m = mod_of(key);
    case (it.opcode)
      OP_PRESS: begin
        if (bit_m != '0) begin
          held_mods = held_mods | bit_m;
        end else begin
          hit = 1'b0;
          if (key == key_cfg[CFG_KEYPAD_INSERT]) key = key_cfg[CFG_INSERT];
          if (awaiting) begin
            awaiting = 1'b0;
            ticks_left = '0;
            if (hotkeys[await_slot].second_key == key &&
                hotkeys[await_slot].modifiers == held_mods) begin
              r.activated = 1'b1;
              r.fired_handle = hotkeys[await_slot].handle;
              r.matched = 1'b1;
              hit = 1'b1;
            end
          end
          for (i = 0; i < TABLE_SLOTS && !hit; i++) begin
            if (hotkey_on[i] && hotkeys[i].first_key == key &&
                hotkeys[i].modifiers == held_mods) begin
              hit = 1'b1;
              r.matched = 1'b1;
              if (hotkeys[i].second_key == '0) begin
                r.activated = 1'b1;
                r.fired_handle = hotkeys[i].handle;
              end else begin
                awaiting = 1'b1;
                await_slot = i[IDX_W-1:0];
                ticks_left = TIMER_W'(WAIT_TICKS);
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        held_mods = held_mods & ~bit_m;
      end
      OP_TICK: begin
        if (awaiting) begin
          if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            ticks_left = '0;
            awaiting = 1'b0;
          end
        end
      end
      default: begin
        hotkey_on[it.entry_index] = it.entry_valid;
        hotkeys[it.entry_index] = entry_of(it);
        if (awaiting && await_slot == it.entry_index) begin
          awaiting = 1'b0;
          ticks_left = '0;
        end
      end
    endcase
    r.waiting_second = awaiting;
    r.modifiers_now = held_mods;
    return r;
  endfunction

  function automatic item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] hot_key();
    int s;
    s = $urandom_range(0, TABLE_SLOTS - 1);
    case ($urandom_range(0, 3))
      0: return gen_tab[s].first_key;
      1: return gen_tab[s].second_key;
      2: return key_cfg[$urandom_range(0, CFG_REGS - 1)];
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 3) == 0) return KEY_W'($urandom);
    return KEY_W'(8'h30 + $urandom_range(0, 7));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(item_t it);
    key_events.push_back(it);
    gen_count++;
    case (it.opcode)
      OP_PRESS:   gen_mods = gen_mods | mod_of(it.keycode);
      OP_RELEASE: gen_mods = gen_mods & ~mod_of(it.keycode);
      OP_WRITE: begin
        gen_tab[it.entry_index] = entry_of(it);
        gen_on[it.entry_index] = it.entry_valid;
      end
      default: ;
    endcase
  endtask

  task automatic send_key(opcode_t op, logic [KEY_W-1:0] k);
    item_t it;
    it = noise_item();
    it.opcode = op;
    it.keycode = k;
    send(it);
  endtask

  task automatic send_write(int idx, logic [KEY_W-1:0] first, logic [KEY_W-1:0] second,
                            logic [MOD_W-1:0] mods, logic [HANDLE_W-1:0] handle,
                            logic valid);
    item_t it;
    it = noise_item();
    it.opcode = OP_WRITE;
    it.entry_index = IDX_W'(idx);
    it.entry_first_key = first;
    it.entry_second_key = second;
    it.entry_modifiers = mods;
    it.entry_handle = handle;
    it.entry_valid = valid;
    send(it);
  endtask

  task automatic write_random_entry(int idx);
    logic [KEY_W-1:0] first;
    logic [KEY_W-1:0] second;
    first = pool_key();
    if ($urandom_range(0, 5) == 0) first = key_cfg[CFG_INSERT];
    second = ($urandom_range(0, 9) < 4) ? '0 : pool_key();
    send_write(idx, first, second, MOD_W'($urandom_range(0, 7)), HANDLE_W'($urandom),
               $urandom_range(0, 9) != 0);
  endtask

  // press a key, using keypad insert for insert now and then
  task automatic press_key(logic [KEY_W-1:0] k);
    if (k == key_cfg[CFG_INSERT] && $urandom_range(0, 1) == 1)
      send_key(OP_PRESS, key_cfg[CFG_KEYPAD_INSERT]);
    else
      send_key(OP_PRESS, k);
  endtask

  task automatic set_mods(logic [MOD_W-1:0] want);
    logic [MOD_W-1:0] b;
    logic [KEY_W-1:0] c0;
    logic [KEY_W-1:0] c1;
    int               n;
    int               pick;
    for (n = 0; n < MOD_W; n++) begin
      b = MOD_W'(1) << n;
      pick = $urandom_range(0, 1);
      c0 = key_cfg[2 * n + pick];
      c1 = key_cfg[2 * n + 1 - pick];
      if ((want & b) != (gen_mods & b)) begin
        if (mod_of(c1) == b) c0 = c1;
        if (mod_of(c0) == b) begin
          if ((want & b) != '0) send_key(OP_PRESS, c0);
          else send_key(OP_RELEASE, c0);
        end
      end
    end
  endtask

  task automatic play_hotkey();
    int s;
    int tries;
    s = $urandom_range(0, TABLE_SLOTS - 1);
    for (tries = 0; tries < 8 && !gen_on[s]; tries++) s = $urandom_range(0, TABLE_SLOTS - 1);
    if (!gen_on[s]) write_random_entry(s);
    set_mods(gen_tab[s].modifiers);
    press_key(gen_tab[s].first_key);
    if (gen_tab[s].second_key != '0) begin
      repeat ($urandom_range(0, 2)) send_key(OP_TICK, KEY_W'($urandom));
      case ($urandom_range(0, 9))
        0: press_key(hot_key());
        1: press_key(gen_tab[$urandom_range(0, TABLE_SLOTS - 1)].first_key);
        default: press_key(gen_tab[s].second_key);
      endcase
    end
    if ($urandom_range(0, 3) == 0) set_mods('0);
  endtask

  task automatic run_random(int n);
    int target;
    target = gen_count + n;
    repeat (6) write_random_entry($urandom_range(0, TABLE_SLOTS - 1));
    while (gen_count < target) begin
      case ($urandom_range(0, 19))
        0, 1: write_random_entry($urandom_range(0, TABLE_SLOTS - 1));
        2: send(noise_item());
        3: repeat ($urandom_range(1, 4)) send_key(OP_TICK, KEY_W'($urandom));
        4: send_key(OP_RELEASE, hot_key());
        5, 6: press_key(hot_key());
        default: play_hotkey();
      endcase
    end
  endtask

  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (key_events.size() != 0 || start || predicted_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_codes(logic [CFG_REGS*KEY_W-1:0] codes);
    int r;
    for (r = 0; r < CFG_REGS; r++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_data <= codes[r*KEY_W +: KEY_W];
      key_cfg[r] = codes[r*KEY_W +: KEY_W];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d, expected %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(hotkey_step(item));
        accepted++;
        if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (key_events.size() != 0) begin
          item <= key_events.pop_front();
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        report("result with nothing outstanding", 1, 0);
      end else begin
        want = predicted_results.pop_front();
        if (result.activated !== want.activated)
          report("activated", result.activated, want.activated);
        if (result.fired_handle !== want.fired_handle)
          report("fired_handle", result.fired_handle, want.fired_handle);
        if (result.matched !== want.matched)
          report("matched", result.matched, want.matched);
        if (result.waiting_second !== want.waiting_second)
          report("waiting_second", result.waiting_second, want.waiting_second);
        if (result.modifiers_now !== want.modifiers_now)
          report("modifiers_now", result.modifiers_now, want.modifiers_now);
        if (want.activated) fired++;
        if (want.matched && want.waiting_second && !want.activated) armed++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL two_key_hotkey_matcher");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < CFG_REGS; r++) key_cfg[r] = '0;
    held_mods = '0;
    awaiting = 1'b0;
    await_slot = '0;
    ticks_left = '0;
    hotkey_on = '0;
    gen_on = '0;
    gen_mods = '0;
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      hotkeys[s] = '0;
      gen_tab[s] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_random(50);
    wait_quiet();

    load_codes({8'h52, 8'h6E, 8'h64, 8'h38, 8'h61, 8'h1D, 8'h36, 8'h2A});
    send_write(0, 8'h10, 8'h00, '0, 8'hFF, 1'b1);
    send_write(1, 8'h10, 8'h00, '0, 8'h01, 1'b1);
    send_key(OP_PRESS, 8'h10);
    send_write(2, 8'h20, 8'h21, SHIFT_BIT | CTRL_BIT, 8'hA5, 1'b1);
    send_key(OP_PRESS, 8'h2A);
    send_key(OP_PRESS, 8'h61);
    send_key(OP_PRESS, 8'h20);
    send_key(OP_PRESS, 8'h38);
    send_key(OP_RELEASE, 8'h64);
    send_key(OP_PRESS, 8'h21);
    send_key(OP_PRESS, 8'h20);
    send_key(OP_PRESS, 8'h20);
    send_key(OP_TICK, 8'h00);
    send_write(2, 8'h20, 8'h21, SHIFT_BIT | CTRL_BIT, 8'hA5, 1'b1);
    send_key(OP_PRESS, 8'h20);
    send_key(OP_PRESS, 8'h99);
    send_key(OP_RELEASE, 8'h99);
    send_key(OP_TICK, 8'hFF);
    send_write(3, 8'h6E, 8'h00, SHIFT_BIT | CTRL_BIT, 8'h33, 1'b1);
    send_key(OP_PRESS, 8'h52);
    send_write(15, 8'hFF, 8'hFF, SHIFT_BIT | CTRL_BIT | ALT_BIT, 8'h00, 1'b1);
    send_write(15, 8'hFF, 8'hFF, SHIFT_BIT | CTRL_BIT | ALT_BIT, 8'hFF, 1'b0);
    send_key(OP_RELEASE, 8'h2A);
    send_key(OP_RELEASE, 8'h1D);
    send_write(4, 8'h00, 8'h00, '0, 8'h80, 1'b1);
    send_key(OP_PRESS, 8'h00);
    // let one wait run out on its last tick
    send_write(5, 8'h40, 8'h41, '0, 8'h5A, 1'b1);
    send_key(OP_PRESS, 8'h40);
    repeat (WAIT_TICKS) send_key(OP_TICK, KEY_W'($urandom));
    send_key(OP_PRESS, 8'h41);
    run_random(50);
    wait_quiet();

    // overlapping codes: shift shadows one ctrl code, ctrl shadows one alt code
    load_codes({8'h7F, 8'hFF, 8'h80, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'h00});
    run_random(50);
    wait_quiet();

    load_codes({$urandom, $urandom});
    run_random(40);
    wait_quiet();

    load_codes({CFG_REGS{8'hFF}});
    run_random(30);
    wait_quiet();

    $display("covered %0d items over five modifier code settings, %0d results checked",
             accepted, checked);
    $display("%0d hotkeys fired, %0d second-key waits armed, %0d mismatches",
             fired, armed, errors);
    if (errors == 0) begin
      $display("PASS two_key_hotkey_matcher");
    end else begin
      $display("FAIL two_key_hotkey_matcher");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hkm_pkg.sv
rtl/core/hkm_queue.sv
rtl/core/hkm_front.sv
rtl/core/hkm_back.sv
rtl/core/two_key_hotkey_matcher.sv
rtl/core/hkm_checker.sv
sim/tb_two_key_hotkey_matcher.sv
